[rtl/core/bcnr_pkg.sv]
`default_nettype none
package bcnr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 32;

  // widths of the internal datapath
  localparam int ZR_W  = 35;   // heading in q30 before reduction
  localparam int Z_W   = 33;   // folded angle and cordic residual
  localparam int CS_W  = 33;   // cordic x and y in q30
  localparam int PR_W  = 58;   // half size times cos or sin
  localparam int LC_W  = 26;   // rounded projection, q10.16
  localparam int OFS_W = 27;   // corner offset from center
  localparam int CEN_W = 34;   // box center
  localparam int SUM_W = 36;   // corner before saturation

  localparam logic signed [ZR_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZR_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [ZR_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CS_W-1:0] GAIN_Q30    = 33'sd652032874;

  localparam logic [2:0] SIDE_CENTER = 3'd0;
  localparam logic [2:0] SIDE_REAR   = 3'd1;
  localparam logic [2:0] SIDE_FRONT  = 3'd2;
  localparam logic [2:0] SIDE_RIGHT  = 3'd3;
  localparam logic [2:0] SIDE_LEFT   = 3'd4;

  localparam logic [2:0] CORNER_0    = 3'd0;
  localparam logic [2:0] CORNER_1    = 3'd1;
  localparam logic [2:0] CORNER_2    = 3'd2;
  localparam logic [2:0] CORNER_3    = 3'd3;
  localparam logic [2:0] CORNER_LAST = 3'd4;

  typedef struct packed {
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic [23:0]        half_len;
    logic [23:0]        half_wid;
    logic [2:0]         side_code;
  } pay_t;

  typedef struct packed {
    logic signed [CEN_W-1:0] cx;
    logic signed [CEN_W-1:0] cy;
    logic signed [OFS_W-1:0] r1x;
    logic signed [OFS_W-1:0] r1y;
    logic signed [OFS_W-1:0] r2x;
    logic signed [OFS_W-1:0] r2y;
  } box_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/bcnr_angle.sv]
`default_nettype none
module bcnr_angle (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      in_valid,
  input  wire bcnr_pkg::pay_t            in_pay,
  input  wire logic signed [19:0]        heading,
  output logic                           out_valid,
  output bcnr_pkg::pay_t                 out_pay,
  output logic signed [bcnr_pkg::Z_W-1:0] out_z,
  output logic                           out_neg
);

  logic                                va, vb;
  bcnr_pkg::pay_t                      pa, pb;
  logic signed [bcnr_pkg::ZR_W-1:0]    za, zb, zb_next;
  logic signed [bcnr_pkg::ZR_W-1:0]    zc_full;
  logic                                neg_next;

  // one wrap by two pi is enough for any 20-bit heading
  always_comb begin
    if (za > bcnr_pkg::PI_Q30) begin
      zb_next = za - bcnr_pkg::TWO_PI_Q30;
    end else if (za < -bcnr_pkg::PI_Q30) begin
      zb_next = za + bcnr_pkg::TWO_PI_Q30;
    end else begin
      zb_next = za;
    end
  end

  // fold into the right half plane, cos and sin change sign
  always_comb begin
    if (zb > bcnr_pkg::HALF_PI_Q30) begin
      zc_full  = zb - bcnr_pkg::PI_Q30;
      neg_next = 1'b1;
    end else if (zb < -bcnr_pkg::HALF_PI_Q30) begin
      zc_full  = zb + bcnr_pkg::PI_Q30;
      neg_next = 1'b1;
    end else begin
      zc_full  = zb;
      neg_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa      <= in_pay;
      za      <= {heading[19], heading, 14'd0};
      pb      <= pa;
      zb      <= zb_next;
      out_pay <= pb;
      out_z   <= zc_full[bcnr_pkg::Z_W-1:0];
      out_neg <= neg_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/bcnr_cordic.sv]
`default_nettype none
module bcnr_cordic #(
  parameter int CORDIC_STEPS = bcnr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire bcnr_pkg::pay_t              in_pay,
  input  wire logic signed [bcnr_pkg::Z_W-1:0] in_z,
  input  wire logic                        in_neg,
  output logic                             out_valid,
  output bcnr_pkg::pay_t                   out_pay,
  output logic signed [bcnr_pkg::CS_W-1:0] out_x,
  output logic signed [bcnr_pkg::CS_W-1:0] out_y,
  output logic                             out_neg
);

  logic                             v  [0:CORDIC_STEPS];
  bcnr_pkg::pay_t                   p  [0:CORDIC_STEPS];
  logic signed [bcnr_pkg::CS_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [bcnr_pkg::CS_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [bcnr_pkg::Z_W-1:0]  zs [0:CORDIC_STEPS];
  logic                             ng [0:CORDIC_STEPS];

  assign v[0]  = in_valid;
  assign p[0]  = in_pay;
  assign xs[0] = bcnr_pkg::GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = in_z;
  assign ng[0] = in_neg;

  // one rotation step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [bcnr_pkg::Z_W-1:0] ATAN =
      bcnr_pkg::Z_W'(bcnr_pkg::atan_q30(5'(i)));
    logic signed [bcnr_pkg::CS_W-1:0] xsh, ysh;

    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p[i+1]  <= p[i];
        ng[i+1] <= ng[i];
        if (!zs[i][bcnr_pkg::Z_W-1]) begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + ATAN;
        end
      end
    end
  end

  // residual angle of the last step is not needed
  logic unused_z;
  assign unused_z = ^zs[CORDIC_STEPS];

  assign out_valid = v[CORDIC_STEPS] & ~(unused_z & 1'b0);
  assign out_pay   = p[CORDIC_STEPS];
  assign out_x     = xs[CORDIC_STEPS];
  assign out_y     = ys[CORDIC_STEPS];
  assign out_neg   = ng[CORDIC_STEPS];

endmodule
`default_nettype wire

[rtl/core/bcnr_geom.sv]
`default_nettype none
module bcnr_geom (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire bcnr_pkg::pay_t              in_pay,
  input  wire logic signed [bcnr_pkg::CS_W-1:0] in_x,
  input  wire logic signed [bcnr_pkg::CS_W-1:0] in_y,
  input  wire logic                        in_neg,
  output logic                             out_valid,
  output bcnr_pkg::box_t                   out_box
);

  localparam int PW = bcnr_pkg::PR_W;
  localparam int LW = bcnr_pkg::LC_W;
  localparam int CW = bcnr_pkg::CEN_W;
  localparam int OW = bcnr_pkg::OFS_W;
  localparam logic signed [PW-1:0] RND = PW'(64'sd1 <<< 29);

  logic                             vn, vm, vr;
  bcnr_pkg::pay_t                   pn, pm, pr;
  logic signed [bcnr_pkg::CS_W-1:0] cs, sn;
  logic signed [PW-1:0]             plc, pls, pwc, pws;
  logic signed [PW-1:0]             qlc, qls, qwc, qws;
  logic signed [LW-1:0]             lc, ls, wc, ws;
  logic signed [CW-1:0]             x0, y0, cx_next, cy_next;
  logic signed [CW-1:0]             elc, els, ewc, ews;

  assign qlc = plc + RND;
  assign qls = pls + RND;
  assign qwc = pwc + RND;
  assign qws = pws + RND;

  assign x0  = CW'($signed(pr.ref_x));
  assign y0  = CW'($signed(pr.ref_y));
  assign elc = CW'(lc);
  assign els = CW'(ls);
  assign ewc = CW'(wc);
  assign ews = CW'(ws);

  // move the measured point to the box center
  always_comb begin
    unique case (pr.side_code)
      bcnr_pkg::SIDE_REAR: begin
        cx_next = x0 + elc;
        cy_next = y0 + els;
      end
      bcnr_pkg::SIDE_FRONT: begin
        cx_next = x0 - elc;
        cy_next = y0 - els;
      end
      bcnr_pkg::SIDE_RIGHT: begin
        cx_next = x0 - ews;
        cy_next = y0 + ewc;
      end
      bcnr_pkg::SIDE_LEFT: begin
        cx_next = x0 + ews;
        cy_next = y0 - ewc;
      end
      default: begin
        cx_next = x0;
        cy_next = y0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vn        <= 1'b0;
      vm        <= 1'b0;
      vr        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vn        <= in_valid;
      vm        <= vn;
      vr        <= vm;
      out_valid <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // sign of the fold is applied before rounding
      pn  <= in_pay;
      cs  <= in_neg ? -in_x : in_x;
      sn  <= in_neg ? -in_y : in_y;
      pm  <= pn;
      plc <= $signed({1'b0, pn.half_len}) * cs;
      pls <= $signed({1'b0, pn.half_len}) * sn;
      pwc <= $signed({1'b0, pn.half_wid}) * cs;
      pws <= $signed({1'b0, pn.half_wid}) * sn;
      pr  <= pm;
      lc  <= qlc[LW+29:30];
      ls  <= qls[LW+29:30];
      wc  <= qwc[LW+29:30];
      ws  <= qws[LW+29:30];
      out_box.cx  <= cx_next;
      out_box.cy  <= cy_next;
      out_box.r1x <= -OW'(lc) - OW'(ws);
      out_box.r1y <= -OW'(ls) + OW'(wc);
      out_box.r2x <= OW'(lc) - OW'(ws);
      out_box.r2y <= OW'(ls) + OW'(wc);
    end
  end

endmodule
`default_nettype wire

[rtl/core/bcnr_emit.sv]
`default_nettype none
module bcnr_emit #(
  parameter int COORD_WIDTH = bcnr_pkg::COORD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire bcnr_pkg::box_t in_box,
  output logic                ready,
  output logic                strobe,
  output logic signed [31:0]  corner_x,
  output logic signed [31:0]  corner_y,
  output logic [2:0]          corner_index,
  output logic                last_corner,
  output logic                clipped
);

  localparam int SW = bcnr_pkg::SUM_W;

  logic                 active;
  logic [2:0]           cnt;
  bcnr_pkg::box_t       box;
  logic                 take;
  logic signed [SW-1:0] ox, oy, bx, by, sx, sy, satx, saty;
  logic                 sub, ovx, ovy;

  assign ready = !active || (cnt == bcnr_pkg::CORNER_LAST);
  assign take  = in_valid && ready;

  // corner k is center plus or minus one of the two offsets
  always_comb begin
    unique case (cnt)
      bcnr_pkg::CORNER_1: begin
        ox = SW'(box.r2x); oy = SW'(box.r2y); sub = 1'b0;
      end
      bcnr_pkg::CORNER_2: begin
        ox = SW'(box.r1x); oy = SW'(box.r1y); sub = 1'b1;
      end
      bcnr_pkg::CORNER_3: begin
        ox = SW'(box.r2x); oy = SW'(box.r2y); sub = 1'b1;
      end
      default: begin
        ox = SW'(box.r1x); oy = SW'(box.r1y); sub = 1'b0;
      end
    endcase
  end

  assign bx = SW'(box.cx);
  assign by = SW'(box.cy);
  assign sx = sub ? bx - ox : bx + ox;
  assign sy = sub ? by - oy : by + oy;

  if (COORD_WIDTH < SW) begin : g_sat
    logic [SW-COORD_WIDTH:0] tx, ty;
    assign tx   = sx[SW-1:COORD_WIDTH-1];
    assign ty   = sy[SW-1:COORD_WIDTH-1];
    assign ovx  = (|tx) && !(&tx);
    assign ovy  = (|ty) && !(&ty);
    assign satx = ovx ? {{(SW-COORD_WIDTH+1){sx[SW-1]}}, {(COORD_WIDTH-1){~sx[SW-1]}}} : sx;
    assign saty = ovy ? {{(SW-COORD_WIDTH+1){sy[SW-1]}}, {(COORD_WIDTH-1){~sy[SW-1]}}} : sy;
  end else begin : g_wide
    assign ovx  = 1'b0;
    assign ovy  = 1'b0;
    assign satx = sx;
    assign saty = sy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= bcnr_pkg::CORNER_0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (take) begin
        active <= 1'b1;
        cnt    <= bcnr_pkg::CORNER_0;
      end else if (active) begin
        if (cnt == bcnr_pkg::CORNER_LAST) begin
          active <= 1'b0;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      box <= in_box;
    end
    corner_x     <= satx[31:0];
    corner_y     <= saty[31:0];
    corner_index <= cnt;
    last_corner  <= (cnt == bcnr_pkg::CORNER_LAST);
    clipped      <= ovx | ovy;
  end

endmodule
`default_nettype wire

[rtl/core/box_corners_from_nearest_side_top.sv]
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+--------------------------
// request   | ref_x ref_y half_len half_wid heading        | taken when start && !busy
//           | side_code                                    |
// corner    | corner_x corner_y corner_index last_corner   | strobe, one cycle each
//           | clipped                                      |
//
// the five corners of a request follow on consecutive cycles; the sustained
// request rate is set by the single corner port, which gives out five corners
// per request. requests can enter back to back until the pipeline fills.
// busy rises when the last pipeline stage holds a box and the corner emitter
// has not reached its fifth corner; the whole pipeline then holds.
// rst is synchronous and clears all valid bits and the emitter.
`default_nettype none
module box_corners_from_nearest_side_top #(
  parameter int CORDIC_STEPS = bcnr_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_WIDTH  = bcnr_pkg::COORD_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] ref_x,
  input  wire logic signed [31:0] ref_y,
  input  wire logic [23:0]        half_len,
  input  wire logic [23:0]        half_wid,
  input  wire logic signed [19:0] heading,
  input  wire logic [2:0]         side_code,
  output logic                    strobe,
  output logic signed [31:0]      corner_x,
  output logic signed [31:0]      corner_y,
  output logic [2:0]              corner_index,
  output logic                    last_corner,
  output logic                    clipped
);

  logic                             adv;
  bcnr_pkg::pay_t                   in_pay;
  logic                             ang_valid, cor_valid, box_valid, emit_ready;
  bcnr_pkg::pay_t                   ang_pay, cor_pay;
  logic signed [bcnr_pkg::Z_W-1:0]  ang_z;
  logic                             ang_neg, cor_neg;
  logic signed [bcnr_pkg::CS_W-1:0] cor_x, cor_y;
  bcnr_pkg::box_t                   box;

  assign adv  = !box_valid || emit_ready;
  assign busy = !adv;

  assign in_pay.ref_x     = ref_x;
  assign in_pay.ref_y     = ref_y;
  assign in_pay.half_len  = half_len;
  assign in_pay.half_wid  = half_wid;
  assign in_pay.side_code = side_code;

  bcnr_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (start),
    .in_pay    (in_pay),
    .heading   (heading),
    .out_valid (ang_valid),
    .out_pay   (ang_pay),
    .out_z     (ang_z),
    .out_neg   (ang_neg)
  );

  bcnr_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (ang_valid),
    .in_pay    (ang_pay),
    .in_z      (ang_z),
    .in_neg    (ang_neg),
    .out_valid (cor_valid),
    .out_pay   (cor_pay),
    .out_x     (cor_x),
    .out_y     (cor_y),
    .out_neg   (cor_neg)
  );

  bcnr_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (cor_valid),
    .in_pay    (cor_pay),
    .in_x      (cor_x),
    .in_y      (cor_y),
    .in_neg    (cor_neg),
    .out_valid (box_valid),
    .out_box   (box)
  );

  bcnr_emit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (box_valid),
    .in_box       (box),
    .ready        (emit_ready),
    .strobe       (strobe),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .corner_index (corner_index),
    .last_corner  (last_corner),
    .clipped      (clipped)
  );

endmodule
`default_nettype wire

[rtl/core/bcnr_check.sv]
`default_nettype none
module bcnr_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               strobe,
  input wire logic signed [31:0] corner_x,
  input wire logic signed [31:0] corner_y,
  input wire logic [2:0]         corner_index,
  input wire logic               last_corner
);

  // corners of one request come on consecutive cycles
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    strobe && (corner_index != bcnr_pkg::CORNER_LAST)
      |=> strobe && (corner_index == $past(corner_index) + 3'd1))
    else $error("corner index did not advance");

  // a burst starts at the first corner
  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    !strobe |=> !strobe || (corner_index == bcnr_pkg::CORNER_0))
    else $error("corner burst did not start at corner 0");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last_corner == (corner_index == bcnr_pkg::CORNER_LAST)))
    else $error("last_corner does not match corner index");

  // the closing corner repeats the first
  a_closed: assert property (@(posedge clk) disable iff (rst)
    strobe && (corner_index == bcnr_pkg::CORNER_LAST)
      |-> (corner_x == $past(corner_x, 4)) && (corner_y == $past(corner_y, 4)))
    else $error("closing corner differs from first corner");

  a_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

endmodule

bind box_corners_from_nearest_side_top bcnr_check u_bcnr_check (
  .clk          (clk),
  .rst          (rst),
  .strobe       (strobe),
  .corner_x     (corner_x),
  .corner_y     (corner_y),
  .corner_index (corner_index),
  .last_corner  (last_corner)
);
`default_nettype wire

[tb/sv/box_corner_check_pkg.sv]
`default_nettype none
package box_corner_check_pkg;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [2:0]  idx;
    logic        last;
    logic        clip;
  } corner_t;

  localparam longint ROT_GAIN     = 64'sd652032874;
  localparam longint ROT_PI       = 64'sd3373259426;
  localparam longint ROT_HALF_PI  = 64'sd1686629713;
  localparam longint ROT_TWO_PI   = 64'sd6746518852;
  localparam int     ARCTAN_COUNT = 24;
  localparam longint ARCTAN_Q30 [ARCTAN_COUNT] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
  };

  class box_corner_checker;
    int steps;
    int coord_w;
    corner_t expected_corners[$];
    int n_requests;
    int n_corners;
    int n_clipped;
    int n_errors;

    function new(int steps_p, int coord_w_p);
      steps = steps_p;
      coord_w = coord_w_p;
      n_requests = 0;
      n_corners = 0;
      n_clipped = 0;
      n_errors = 0;
    endfunction

    function int pending();
      return expected_corners.size();
    endfunction

    // cos and sin of a q16 heading, both in q30
    function void rotate(longint hd_q16, output longint cs, output longint sn);
      longint z, x, y, t;
      bit flip;
      int n;
      z = hd_q16 * 16384;
      x = ROT_GAIN;
      y = 0;
      flip = 1'b0;
      while (z > ROT_PI) z -= ROT_TWO_PI;
      while (z < -ROT_PI) z += ROT_TWO_PI;
      // fold into the right half plane, which negates both outputs
      if (z > ROT_HALF_PI) begin
        z -= ROT_PI;
        flip = 1'b1;
      end else if (z < -ROT_HALF_PI) begin
        z += ROT_PI;
        flip = 1'b1;
      end
      n = (steps > ARCTAN_COUNT) ? ARCTAN_COUNT : steps;
      for (int i = 0; i < n; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= ARCTAN_Q30[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += ARCTAN_Q30[i];
        end
        x = t;
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    function longint scale_q30(longint a, longint c);
      return (a * c + (longint'(1) << 29)) >>> 30;
    endfunction

    function logic [31:0] clamp(longint v, inout logic clip);
      longint hi, lo;
      hi = (longint'(1) << (coord_w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        v = hi;
        clip = 1'b1;
      end else if (v < lo) begin
        v = lo;
        clip = 1'b1;
      end
      return v[31:0];
    endfunction

    function void note_request(logic signed [31:0] rx, logic signed [31:0] ry,
                               logic [23:0] hl, logic [23:0] hw,
                               logic signed [19:0] hd, logic [2:0] side);
      longint cx, cy, c, s, lc, ls, wc, ws, r1x, r1y, r2x, r2y;
      longint px[5], py[5];
      corner_t item;
      cx = rx;
      cy = ry;
      rotate(longint'(hd), c, s);
      lc = scale_q30(longint'(hl), c);
      ls = scale_q30(longint'(hl), s);
      wc = scale_q30(longint'(hw), c);
      ws = scale_q30(longint'(hw), s);
      // move the measured point to the box center; other codes mean center
      case (side)
        bcnr_pkg::SIDE_REAR: begin
          cx += lc;
          cy += ls;
        end
        bcnr_pkg::SIDE_FRONT: begin
          cx -= lc;
          cy -= ls;
        end
        bcnr_pkg::SIDE_RIGHT: begin
          cx -= ws;
          cy += wc;
        end
        bcnr_pkg::SIDE_LEFT: begin
          cx += ws;
          cy -= wc;
        end
        default: ;
      endcase
      r1x = -lc - ws;
      r1y = -ls + wc;
      r2x = lc - ws;
      r2y = ls + wc;
      px[0] = cx + r1x; py[0] = cy + r1y;
      px[1] = cx + r2x; py[1] = cy + r2y;
      px[2] = cx - r1x; py[2] = cy - r1y;
      px[3] = cx - r2x; py[3] = cy - r2y;
      px[4] = px[0];    py[4] = py[0];
      for (int k = 0; k < 5; k++) begin
        item.clip = 1'b0;
        item.x = clamp(px[k], item.clip);
        item.y = clamp(py[k], item.clip);
        item.idx = 3'(k);
        item.last = (3'(k) == bcnr_pkg::CORNER_LAST);
        if (item.clip) n_clipped++;
        expected_corners.push_back(item);
      end
      n_requests++;
    endfunction

    function void check_corner(corner_t got);
      corner_t want;
      if (expected_corners.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected corner: x=%h y=%h idx=%0d last=%b clip=%b",
                   got.x, got.y, got.idx, got.last, got.clip);
        return;
      end
      want = expected_corners.pop_front();
      n_corners++;
      if (got.x !== want.x || got.y !== want.y || got.idx !== want.idx ||
          got.last !== want.last || got.clip !== want.clip) begin
        n_errors++;
        if (n_errors <= 10)
          $display("corner mismatch: expected x=%h y=%h idx=%0d last=%b clip=%b,",
                   want.x, want.y, want.idx, want.last, want.clip,
                   " got x=%h y=%h idx=%0d last=%b clip=%b",
                   got.x, got.y, got.idx, got.last, got.clip);
      end
    endfunction
  endclass

endpackage
`default_nettype wire

[tb/sv/box_corners_from_nearest_side_top_test.sv]
`default_nettype none
module box_corners_from_nearest_side_top_test;

  localparam int STEPS    = bcnr_pkg::CORDIC_STEPS_DEF;
  localparam int COORD_W  = bcnr_pkg::COORD_WIDTH_DEF;
  localparam int LATENCY  = STEPS + 9;
  localparam int N_RANDOM = 330;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] ref_x = '0;
  logic signed [31:0] ref_y = '0;
  logic [23:0]        half_len = '0;
  logic [23:0]        half_wid = '0;
  logic signed [19:0] heading = '0;
  logic [2:0]         side_code = '0;
  logic               strobe;
  logic signed [31:0] corner_x;
  logic signed [31:0] corner_y;
  logic [2:0]         corner_index;
  logic               last_corner;
  logic               clipped;

  box_corner_check_pkg::box_corner_checker corner_board = new(STEPS, COORD_W);

  box_corners_from_nearest_side_top #(
    .CORDIC_STEPS(STEPS),
    .COORD_WIDTH (COORD_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .ref_x       (ref_x),
    .ref_y       (ref_y),
    .half_len    (half_len),
    .half_wid    (half_wid),
    .heading     (heading),
    .side_code   (side_code),
    .strobe      (strobe),
    .corner_x    (corner_x),
    .corner_y    (corner_y),
    .corner_index(corner_index),
    .last_corner (last_corner),
    .clipped     (clipped)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy)
      corner_board.note_request(ref_x, ref_y, half_len, half_wid, heading, side_code);
    if (!rst && strobe)
      corner_board.check_corner('{corner_x, corner_y, corner_index, last_corner, clipped});
  end

  // returns at the edge that takes the request
  task automatic send_request(input logic signed [31:0] rx, input logic signed [31:0] ry,
                              input logic [23:0] hl, input logic [23:0] hw,
                              input logic signed [19:0] hd, input logic [2:0] sd);
    start <= 1'b1;
    ref_x <= rx;
    ref_y <= ry;
    half_len <= hl;
    half_wid <= hw;
    heading <= hd;
    side_code <= sd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (corner_board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 32'h03FF_FFFF);
      1:       return 32'h8000_0000 + $urandom_range(0, 32'h03FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_half();
    case ($urandom_range(0, 3))
      0:       return 24'($urandom_range(0, 32'h0000_FFFF));
      1:       return 24'hFF_FFFF - 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    bit paused;
    logic signed [19:0] hd;
    sent = 0;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: null box, each side code, heading extremes, saturation
    send_request(32'sd0, 32'sd0, 24'd0, 24'd0, 20'sd0, bcnr_pkg::SIDE_CENTER);
    send_request(32'sd65536, -32'sd131072, 24'd65536, 24'd32768, 20'sd0,
                 bcnr_pkg::SIDE_CENTER);
    send_request(32'sd65536, -32'sd131072, 24'd65536, 24'd32768, 20'sd68629,
                 bcnr_pkg::SIDE_REAR);
    send_request(32'sd65536, -32'sd131072, 24'd65536, 24'd32768, 20'sd68629,
                 bcnr_pkg::SIDE_FRONT);
    idle(3);
    send_request(32'sd65536, -32'sd131072, 24'd65536, 24'd32768, -20'sd137258,
                 bcnr_pkg::SIDE_RIGHT);
    send_request(32'sd65536, -32'sd131072, 24'd65536, 24'd32768, -20'sd137258,
                 bcnr_pkg::SIDE_LEFT);
    send_request(32'sd1000, 32'sd2000, 24'd300000, 24'd100000, 20'sd51472, 3'd5);
    send_request(32'sd1000, 32'sd2000, 24'd300000, 24'd100000, 20'sd51472, 3'd6);
    send_request(32'sd1000, 32'sd2000, 24'd300000, 24'd100000, 20'sd51472, 3'd7);
    idle(7);
    send_request(32'sd0, 32'sd0, 24'd200000, 24'd90000, 20'sd102944,
                 bcnr_pkg::SIDE_REAR);
    send_request(32'sd0, 32'sd0, 24'd200000, 24'd90000, 20'sd205887,
                 bcnr_pkg::SIDE_FRONT);
    send_request(32'sd0, 32'sd0, 24'd200000, 24'd90000, -20'sd205887,
                 bcnr_pkg::SIDE_RIGHT);
    send_request(32'sd0, 32'sd0, 24'd200000, 24'd90000, 20'sd411775,
                 bcnr_pkg::SIDE_LEFT);
    send_request(32'sd0, 32'sd0, 24'd200000, 24'd90000, -20'sd411775,
                 bcnr_pkg::SIDE_CENTER);
    // headings outside two pi, then corners that saturate
    send_request(32'sd0, 32'sd0, 24'd200000, 24'd90000, 20'sh7FFFF,
                 bcnr_pkg::SIDE_REAR);
    send_request(32'sd0, 32'sd0, 24'd200000, 24'd90000, 20'sh80000,
                 bcnr_pkg::SIDE_FRONT);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 20'sd51472,
                 bcnr_pkg::SIDE_CENTER);
    send_request(32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, -20'sd51472,
                 bcnr_pkg::SIDE_LEFT);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 20'sd0,
                 bcnr_pkg::SIDE_REAR);
    wait_drained();

    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        if ($urandom_range(0, 7) == 0)
          hd = 20'($urandom);
        else
          hd = 20'(int'($urandom_range(0, 823550)) - 411775);
        send_request(pick_coord(), pick_coord(), pick_half(), pick_half(), hd,
                     3'($urandom_range(0, 7)));
        sent++;
      end
      if (!paused && sent >= N_RANDOM / 2) begin
        paused = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        idle($urandom_range(1, 3 * LATENCY / 2));
      end
    end

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("summary: %0d boxes, %0d corners checked, %0d saturated corners",
             corner_board.n_requests, corner_board.n_corners, corner_board.n_clipped);
    $display("summary: all side codes, full heading field, bursts and gaps of the sender");
    if (corner_board.n_errors == 0 && corner_board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d failures, %0d corners still expected", corner_board.n_errors,
               corner_board.pending());
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

[box_corners_from_nearest_side_top.f]
rtl/core/bcnr_pkg.sv
rtl/core/bcnr_angle.sv
rtl/core/bcnr_cordic.sv
rtl/core/bcnr_geom.sv
rtl/core/bcnr_emit.sv
rtl/core/box_corners_from_nearest_side_top.sv
rtl/core/bcnr_check.sv
tb/sv/box_corner_check_pkg.sv
tb/sv/box_corners_from_nearest_side_top_test.sv
